[design/tdc_readout_word_reformatter_unit_defines.svh]
// assertion macros for the reformatter back end
`ifndef TDC_READOUT_WORD_REFORMATTER_UNIT_DEFINES_SVH
`define TDC_READOUT_WORD_REFORMATTER_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define TRWR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("trwr assertion failed");

// next-cycle implication
`define TRWR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("trwr assertion failed");

`else

`define TRWR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TRWR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/trwr_pkg.sv]
`timescale 1ns / 1ps

package trwr_pkg;

	localparam int SLOT_W = 5;
	localparam int CNT_W = 14;
	localparam int POS_W = 12;
	localparam int WORD_W = 32;
	localparam int BASE_W = 5;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int POS_FIELD_MAX = 4095;

	localparam int DEF_MAX_EVENT_WORDS = 4096;
	localparam int DEF_NUM_SLOTS = 32;

	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = 14'h3FFF;

	// word type codes in bits 31..27
	localparam logic [4:0] TYPE_DATA = 5'h00;
	localparam logic [4:0] TYPE_ERROR = 5'h04;
	localparam logic [4:0] TYPE_GHEADER = 5'h08;
	localparam logic [4:0] TYPE_GTRAILER = 5'h10;
	localparam logic [4:0] TYPE_TTAG = 5'h11;

	// result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_PATCH = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SUBTRACT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_OVERRIDE = 1'd1;

	localparam logic [BASE_W-1:0] BASE_SUBTRACT_RST = 5'd9;
	localparam logic SLOT_OVERRIDE_RST = 1'b1;

	typedef enum logic [2:0] {
		CLS_DATA,
		CLS_HEADER,
		CLS_TTAG,
		CLS_ERROR,
		CLS_TRAILER,
		CLS_OTHER
	} cls_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [SLOT_W-1:0] expected_slot;
		logic              event_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [WORD_W-1:0] out_word;
		logic [POS_W-1:0]  header_pos;
		logic              count_mismatch;
		logic [SLOT_W-1:0] out_slot;
	} out_item_t;

	typedef struct packed {
		cls_t              cls;
		logic [WORD_W-1:0] word;
		logic [SLOT_W-1:0] expected_slot;
		logic              event_start;
	} mid_item_t;

	typedef struct packed {
		logic [BASE_W-1:0] base_subtract;
		logic              slot_override;
	} cfg_t;

endpackage

[design/trwr_fifo.sv]
`timescale 1ns / 1ps

module trwr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/trwr_front.sv]
`timescale 1ns / 1ps

module trwr_front
	import trwr_pkg::*;
(
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      mid_wr,
	output mid_item_t mid_item,
	input  logic      mid_full
);

	cls_t       cls;
	logic [4:0] wtype;

	assign wtype = item.word[31:27];

	always_comb begin
		case (wtype)
			TYPE_DATA:     cls = CLS_DATA;
			TYPE_GHEADER:  cls = CLS_HEADER;
			TYPE_TTAG:     cls = CLS_TTAG;
			TYPE_ERROR:    cls = CLS_ERROR;
			TYPE_GTRAILER: cls = CLS_TRAILER;
			default:       cls = CLS_OTHER;
		endcase
	end

	assign full = mid_full;

	// unknown types only matter when they open an event
	assign mid_wr = push && !mid_full && ((cls != CLS_OTHER) || item.event_start);

	assign mid_item.cls = cls;
	assign mid_item.word = item.word;
	assign mid_item.expected_slot = item.expected_slot;
	assign mid_item.event_start = item.event_start;

endmodule

[design/trwr_back.sv]
`timescale 1ns / 1ps

`include "tdc_readout_word_reformatter_unit_defines.svh"

module trwr_back
	import trwr_pkg::*;
#(
	parameter int MAX_EVENT_WORDS = DEF_MAX_EVENT_WORDS,
	parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  mid_item_t it,
	input  logic      mid_empty,
	output logic      mid_pop,
	input  logic      out_full,
	output logic      res_push,
	output out_item_t res
);

	localparam int POS_CAP_I = (MAX_EVENT_WORDS - 1 < POS_FIELD_MAX) ?
		MAX_EVENT_WORDS - 1 : POS_FIELD_MAX;
	localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_I);
	localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
	localparam logic [SLOT_W:0] NUM_SLOTS_V = (SLOT_W + 1)'(NUM_SLOTS);

	logic [SLOT_W-1:0]    cur_slot_q;
	logic [CNT_W-1:0]     words_q;
	logic [CNT_W-1:0]     sub_q;
	logic [POS_W-1:0]     hdr_pos_q;
	logic [POS_W-1:0]     out_pos_q;
	logic [NUM_SLOTS-1:0] err_flags_q;

	logic              take;
	logic [POS_W-1:0]  pos_base;
	logic [POS_W-1:0]  pos_adv;
	logic [SLOT_W-1:0] hdr_slot;
	logic [CNT_W-1:0]  words_inc;
	logic [CNT_W-1:0]  sub_inc;
	logic [CNT_W-1:0]  corr;
	logic              slot_in_range;

	assign take = !mid_empty && !out_full;
	assign mid_pop = take;

	assign pos_base = it.event_start ? '0 : out_pos_q;
	assign pos_adv = (pos_base < POS_CAP) ? pos_base + 1'b1 : pos_base;

	assign hdr_slot = (cfg.slot_override && (it.word[SLOT_W-1:0] != it.expected_slot)) ?
		it.expected_slot : it.word[SLOT_W-1:0];

	assign words_inc = (words_q != CNT_MAX) ? words_q + 1'b1 : words_q;
	assign sub_inc = (sub_q != CNT_MAX) ? sub_q + 1'b1 : sub_q;

	// trailer count minus subtract, wraps in 14 bits
	assign corr = it.word[CNT_W+4:5] - sub_q;

	assign slot_in_range = ({1'b0, cur_slot_q} < NUM_SLOTS_V);

	always_comb begin
		res_push = 1'b0;
		res.kind = KIND_DATA;
		res.out_word = '0;
		res.header_pos = hdr_pos_q;
		res.count_mismatch = 1'b0;
		res.out_slot = cur_slot_q;
		case (it.cls)
			CLS_DATA: begin
				res_push = take;
				res.kind = KIND_DATA;
				res.out_word = it.word | {cur_slot_q, {(WORD_W - SLOT_W){1'b0}}};
			end
			CLS_HEADER: begin
				res_push = take;
				res.kind = KIND_HEADER;
				res.out_word = {{(WORD_W - SLOT_W){1'b0}}, hdr_slot};
				res.header_pos = pos_base;
				res.out_slot = hdr_slot;
			end
			CLS_ERROR: begin
				res_push = take;
				res.kind = KIND_ERROR;
				res.out_word = {17'b0, it.word[14:0]};
			end
			CLS_TRAILER: begin
				res_push = take;
				res.kind = KIND_PATCH;
				res.out_word = {{(WORD_W - CNT_W - 5){1'b0}}, corr, 5'b0};
				res.count_mismatch = (corr != words_q);
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_slot_q <= '0;
			words_q <= '0;
			sub_q <= '0;
			hdr_pos_q <= '0;
			out_pos_q <= '0;
			err_flags_q <= '0;
		end else if (take) begin
			out_pos_q <= pos_base;
			case (it.cls)
				CLS_HEADER: begin
					cur_slot_q <= hdr_slot;
					words_q <= CNT_W'(1);
					sub_q <= CNT_W'(cfg.base_subtract);
					hdr_pos_q <= pos_base;
					out_pos_q <= pos_adv;
				end
				CLS_DATA: begin
					words_q <= words_inc;
					out_pos_q <= pos_adv;
				end
				CLS_TTAG: begin
					sub_q <= sub_inc;
				end
				CLS_ERROR: begin
					sub_q <= sub_inc;
					if (slot_in_range) begin
						err_flags_q[cur_slot_q[SLOT_IDX_W-1:0]] <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	`TRWR_ASSERT_NEXT(a_err_flag_set, clk, arst_n,
		take && (it.cls == CLS_ERROR) && slot_in_range,
		err_flags_q[$past(cur_slot_q[SLOT_IDX_W-1:0])])
	`TRWR_ASSERT_NEXT(a_header_reload, clk, arst_n, take && (it.cls == CLS_HEADER),
		(words_q == CNT_W'(1)) && (sub_q == CNT_W'($past(cfg.base_subtract))))
	`TRWR_ASSERT_NOW(a_pos_capped, clk, arst_n, 1'b1, out_pos_q <= POS_CAP)
	`TRWR_ASSERT_NOW(a_no_push_full, clk, arst_n, res_push, !out_full && !mid_empty)
	`TRWR_ASSERT_NOW(a_mismatch_patch_only, clk, arst_n, res_push && res.count_mismatch,
		res.kind == KIND_PATCH)

endmodule

[design/tdc_readout_word_reformatter_unit.sv]
`timescale 1ns / 1ps

// tdc readout word reformatter
// input channel: drive item and raise push; the transaction happens on a rising
// edge with push high and full low. one 32-bit readout word per transaction, plus
// the expected slot and an event start mark.
// result channel: while empty is low the oldest result sits on result; raise pop
// to take it. headers, data words, errors and trailer patches give one result;
// time tags and other word types give none.
// a word taken in is written into the middle queue; the back end writes its result
// into the output queue. one word per cycle while the output queue has room, as the
// front end decodes combinationally and the back end counts as it takes each word.
// a two-entry queue sits between front and back and another at the output, so
// a stalled receiver stops the back end only once the output queue fills, and
// full rises once the middle queue fills behind it.
// configuration: wr_en, wr_index and wr_data write base_subtract (index 0) and
// slot_override (index 1); write only while the block is idle.
// reset: both queues empty, counters, positions, slot and error flags cleared,
// base_subtract back to 9 and slot_override back to 1.

module tdc_readout_word_reformatter_unit
	import trwr_pkg::*;
#(
	parameter int MAX_EVENT_WORDS = DEF_MAX_EVENT_WORDS,
	parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  in_item_t              item,
	output logic                  empty,
	input  logic                  pop,
	output out_item_t             result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	logic [BASE_W-1:0] base_subtract_q;
	logic              slot_override_q;
	cfg_t              cfg;

	logic      mid_wr;
	mid_item_t mid_wdata;
	logic      mid_full;
	logic      mid_empty;
	logic      mid_pop;
	mid_item_t mid_rdata;
	logic      res_push;
	out_item_t res;
	logic      out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_subtract_q <= BASE_SUBTRACT_RST;
			slot_override_q <= SLOT_OVERRIDE_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_BASE_SUBTRACT: base_subtract_q <= wr_data[BASE_W-1:0];
				REG_SLOT_OVERRIDE: slot_override_q <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.base_subtract = base_subtract_q;
	assign cfg.slot_override = slot_override_q;

	trwr_front u_front (
		.push     (push),
		.full     (full),
		.item     (item),
		.mid_wr   (mid_wr),
		.mid_item (mid_wdata),
		.mid_full (mid_full)
	);

	trwr_fifo #(
		.WIDTH ($bits(mid_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data (mid_wdata),
		.full    (mid_full),
		.rd_en   (mid_pop),
		.rd_data (mid_rdata),
		.empty   (mid_empty)
	);

	trwr_back #(
		.MAX_EVENT_WORDS (MAX_EVENT_WORDS),
		.NUM_SLOTS       (NUM_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.it        (mid_rdata),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.res_push  (res_push),
		.res       (res)
	);

	trwr_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule

[tb/sv/trwr_result_checker.sv]
`timescale 1ns / 1ps

module trwr_result_checker
	import trwr_pkg::*;
#(
	parameter int MAX_EVENT_WORDS = DEF_MAX_EVENT_WORDS,
	parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  in_item_t              item,
	input  logic                  empty,
	input  logic                  pop,
	input  out_item_t             result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output int                    mismatches,
	output int                    pending
);

	localparam int POS_CAP_RAW = MAX_EVENT_WORDS - 1;
	localparam logic [POS_W-1:0] POS_CAP =
		(POS_CAP_RAW < POS_FIELD_MAX) ? POS_W'(POS_CAP_RAW) : POS_W'(POS_FIELD_MAX);

	logic [BASE_W-1:0] m_base;
	logic              m_override;
	logic [SLOT_W-1:0] m_slot;
	logic [CNT_W-1:0]  m_words;
	logic [CNT_W-1:0]  m_sub;
	logic [POS_W-1:0]  m_hdr_pos;
	logic [POS_W-1:0]  m_pos;
	logic [31:0]       m_err_flags;

	out_item_t reformatted_q[$];

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic void step_position();
		if (m_pos < POS_CAP)
			m_pos = m_pos + 1'b1;
	endfunction

	// updates the model state for one word, returns 1 when a result is due
	function automatic bit reformat_word(input in_item_t it, output out_item_t r);
		logic [SLOT_W-1:0] hslot;
		logic [CNT_W-1:0]  corr;
		r = '0;
		if (it.event_start)
			m_pos = '0;
		case (it.word[31:27])
			TYPE_GHEADER: begin
				hslot = it.word[SLOT_W-1:0];
				if (m_override && hslot != it.expected_slot)
					hslot = it.expected_slot;
				m_slot = hslot;
				m_words = CNT_W'(1);
				m_sub = CNT_W'(m_base);
				m_hdr_pos = m_pos;
				r.kind = KIND_HEADER;
				r.out_word = WORD_W'(hslot);
				step_position();
			end
			TYPE_DATA: begin
				m_words = count_up(m_words);
				r.kind = KIND_DATA;
				r.out_word = it.word | (WORD_W'(m_slot) << 27);
				step_position();
			end
			TYPE_TTAG: begin
				m_sub = count_up(m_sub);
				return 1'b0;
			end
			TYPE_ERROR: begin
				m_sub = count_up(m_sub);
				if (int'(m_slot) < NUM_SLOTS)
					m_err_flags[m_slot] = 1'b1;
				r.kind = KIND_ERROR;
				r.out_word = {17'd0, it.word[14:0]};
			end
			TYPE_GTRAILER: begin
				corr = it.word[18:5] - m_sub;
				r.kind = KIND_PATCH;
				r.out_word = WORD_W'(corr) << 5;
				r.count_mismatch = (corr != m_words);
			end
			default: return 1'b0;
		endcase
		r.header_pos = m_hdr_pos;
		r.out_slot = m_slot;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		out_item_t pred;
		if (!arst_n) begin
			m_base = BASE_SUBTRACT_RST;
			m_override = SLOT_OVERRIDE_RST;
			m_slot = '0;
			m_words = '0;
			m_sub = '0;
			m_hdr_pos = '0;
			m_pos = '0;
			m_err_flags = '0;
			reformatted_q.delete();
			mismatches = 0;
		end else begin
			if (pop && !empty) begin
				if (reformatted_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result transaction with none expected: kind %0d word %h",
							$time, result.kind, result.out_word);
				end else begin
					want = reformatted_q.pop_front();
					if (result.kind !== want.kind || result.out_word !== want.out_word ||
						result.header_pos !== want.header_pos ||
						result.count_mismatch !== want.count_mismatch ||
						result.out_slot !== want.out_slot) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch exp kind %0d word %h pos %0d mism %0d slot %0d",
								$time, want.kind, want.out_word, want.header_pos,
								want.count_mismatch, want.out_slot,
								"\n    got kind %0d word %h pos %0d mism %0d slot %0d",
								result.kind, result.out_word, result.header_pos,
								result.count_mismatch, result.out_slot);
					end
				end
			end
			if (wr_en) begin
				case (wr_index)
					REG_BASE_SUBTRACT: m_base = wr_data[BASE_W-1:0];
					REG_SLOT_OVERRIDE: m_override = wr_data[0];
					default: ;
				endcase
			end
			if (push && !full) begin
				if (reformat_word(item, pred))
					reformatted_q.push_back(pred);
			end
		end
		pending = reformatted_q.size();
	end

endmodule

[tb/sv/tdc_readout_word_reformatter_unit_test.sv]
`timescale 1ns / 1ps

module tdc_readout_word_reformatter_unit_test;
	import trwr_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	in_item_t              item;
	logic                  empty;
	logic                  pop;
	out_item_t             result;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	int mismatches;
	int pending;
	int items_sent;
	bit no_idle;
	bit hold_request;
	logic [BASE_W-1:0] base_now;

	tdc_readout_word_reformatter_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	trwr_result_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tdc_readout_word_reformatter_unit_test: FAIL");
		$finish;
	end

	// receiver side, including the long hold-off that backs the block up
	initial begin : receiver
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				pop <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				pop <= no_idle || ($urandom_range(99) >= 15);
			end
		end
	end

	task automatic send_word(input logic [31:0] w, input logic [4:0] es, input logic st);
		in_item_t it;
		it.word = w;
		it.expected_slot = es;
		it.event_start = st;
		if (!no_idle && $urandom_range(99) < 15) begin
			push <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		item <= it;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		case (w[31:27])
			TYPE_DATA, TYPE_ERROR, TYPE_GHEADER, TYPE_GTRAILER, TYPE_TTAG: items_sent++;
			default: ;
		endcase
	endtask

	// wait until every expected transaction is in, then let trailing words drain
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		for (int i = 0; i < 20000 && pending != 0; i++)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic configure(input logic [BASE_W-1:0] b, input logic ovr);
		wr_en <= 1'b1;
		wr_index <= REG_BASE_SUBTRACT;
		wr_data <= CFG_DATA_W'(b);
		@(posedge clk);
		wr_index <= REG_SLOT_OVERRIDE;
		wr_data <= (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)) | CFG_DATA_W'(ovr);
		@(posedge clk);
		wr_en <= 1'b0;
		base_now = b;
	endtask

	function automatic logic [4:0] ignored_type();
		logic [4:0] t;
		t = 5'($urandom);
		while (t == TYPE_DATA || t == TYPE_ERROR || t == TYPE_GHEADER ||
			t == TYPE_GTRAILER || t == TYPE_TTAG)
			t = 5'($urandom);
		return t;
	endfunction

	// header, a random body, and a trailer whose count is right unless asked otherwise
	task automatic send_board(input int body_len, input bit exact, input logic st);
		logic [4:0]       es;
		logic [4:0]       hs;
		int               nwords;
		int               nsub;
		logic [CNT_W-1:0] n;
		es = 5'($urandom);
		hs = ($urandom_range(3) == 0) ? 5'($urandom) : es;
		send_word({TYPE_GHEADER, 22'($urandom), hs}, es, st);
		nwords = 1;
		nsub = int'(base_now);
		for (int i = 0; i < body_len; i++) begin
			case ($urandom_range(9))
				0: begin
					send_word({TYPE_TTAG, 27'($urandom)}, 5'($urandom), 1'b0);
					nsub++;
				end
				1: begin
					send_word({TYPE_ERROR, 27'($urandom)}, 5'($urandom), 1'b0);
					nsub++;
				end
				2: send_word({ignored_type(), 27'($urandom)}, 5'($urandom),
					$urandom_range(19) == 0);
				default: begin
					send_word({TYPE_DATA, 27'($urandom)}, 5'($urandom),
						$urandom_range(29) == 0);
					nwords++;
				end
			endcase
		end
		n = exact ? CNT_W'(nwords + nsub) : CNT_W'($urandom);
		send_word({TYPE_GTRAILER, 8'($urandom), n, 5'($urandom)}, 5'($urandom), 1'b0);
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		no_idle = 1'b0;
		hold_request = 1'b0;
		items_sent = 0;
		base_now = BASE_SUBTRACT_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// data and trailer before any header use the cleared state
		send_word(32'h0000_0000, 5'd0, 1'b1);
		send_word({TYPE_GTRAILER, 27'd0}, 5'd0, 1'b0);
		send_word({TYPE_GHEADER, 27'd5}, 5'd5, 1'b0);
		send_word({TYPE_DATA, 27'h7FF_FFFF}, 5'd5, 1'b0);
		send_word({TYPE_TTAG, 27'h7FF_FFFF}, 5'd5, 1'b0);
		send_word({TYPE_ERROR, 27'h7FF_FFFF}, 5'd5, 1'b0);
		send_word({5'h01, 27'h7FF_FFFF}, 5'd5, 1'b0);
		send_word({5'h03, 27'h000_1234}, 5'd5, 1'b0);
		send_word({5'h18, 27'h000_0000}, 5'd5, 1'b0);
		send_word(32'hFFFF_FFFF, 5'd5, 1'b0);
		// header plus one data word, base 9 plus tag plus error: count 13 matches
		send_word({TYPE_GTRAILER, 8'h00, 14'd13, 5'h00}, 5'd5, 1'b0);
		send_word({TYPE_GHEADER, 27'h1F}, 5'd3, 1'b1);
		// count below the subtract value wraps
		send_word({TYPE_GTRAILER, 8'hFF, 14'd2, 5'h1F}, 5'd3, 1'b0);
		send_word({TYPE_GTRAILER, 8'h00, 14'h3FFF, 5'h00}, 5'd3, 1'b0);
		settle();

		configure(5'd0, 1'b0);
		send_word({TYPE_GHEADER, 27'h1F}, 5'd0, 1'b1);
		send_word({TYPE_DATA, 27'h123_4567}, 5'd0, 1'b0);
		send_word({TYPE_ERROR, 27'h000_5A5A}, 5'd0, 1'b0);
		send_word({TYPE_GTRAILER, 8'h00, 14'd3, 5'h00}, 5'd0, 1'b0);
		send_word({TYPE_GHEADER, 27'h7FF_FFFF}, 5'h1F, 1'b0);
		send_word({TYPE_GTRAILER, 27'h7FF_FFFF}, 5'h1F, 1'b0);
		settle();

		// a longer board sent with no idle cycles on either side
		configure(5'd31, 1'b1);
		no_idle = 1'b1;
		send_word({TYPE_GHEADER, 27'd7}, 5'd7, 1'b1);
		repeat (24) send_word({TYPE_DATA, 27'($urandom)}, 5'($urandom), 1'b0);
		repeat (8) send_word({TYPE_TTAG, 27'($urandom)}, 5'($urandom), 1'b0);
		send_word({TYPE_ERROR, 27'($urandom)}, 5'd7, 1'b0);
		send_word({TYPE_GTRAILER, 8'h00, 14'h3FFF, 5'h00}, 5'd7, 1'b0);
		send_word({TYPE_GHEADER, 27'd9}, 5'd9, 1'b0);
		send_word({TYPE_DATA, 27'd0}, 5'd9, 1'b0);
		no_idle = 1'b0;
		settle();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: configure(5'd0, 1'b1);
				1: configure(5'd31, 1'b0);
				default: configure(5'($urandom), 1'($urandom));
			endcase
			no_idle = (phase == 2);
			if (phase == 1)
				hold_request = 1'b1;
			items_sent = 0;
			while (items_sent < 90) begin
				if ($urandom_range(4) == 0) begin
					// stray words and broken boards
					case ($urandom_range(2))
						0: send_word($urandom, 5'($urandom), 1'($urandom));
						1: send_word({TYPE_DATA, 27'($urandom)}, 5'($urandom), 1'b0);
						default: send_word({TYPE_GTRAILER, 27'($urandom)}, 5'($urandom), 1'b0);
					endcase
				end else begin
					send_board($urandom_range(12), $urandom_range(4) != 0,
						$urandom_range(2) == 0);
				end
			end
			no_idle = 1'b0;
			settle();
		end

		if (mismatches == 0 && pending == 0)
			$display("tdc_readout_word_reformatter_unit_test: PASS");
		else
			$display("tdc_readout_word_reformatter_unit_test: FAIL");
		$finish;
	end

endmodule

[tdc_readout_word_reformatter_unit.f]
+incdir+design
design/trwr_pkg.sv
design/trwr_fifo.sv
design/trwr_front.sv
design/trwr_back.sv
design/tdc_readout_word_reformatter_unit.sv
tb/sv/trwr_result_checker.sv
tb/sv/tdc_readout_word_reformatter_unit_test.sv
